@@ rtl/swm_pkg.sv @@
// Shared types and constants for the sliding window median block.
package swm_pkg;

    localparam int SampleWidth = 32;
    localparam int CostWidth   = 43;
    localparam int SizeWidth   = 11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_SHIFT,
        ST_CHECK,
        ST_MEDRD,
        ST_COST,
        ST_OUT,
        ST_FIND,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic load;
        logic write_arrival;
        logic scan_start;
        logic scan_step;
        logic shift_step;
        logic med_read;
        logic cost_start;
        logic cost_step;
        logic out_load;
        logic find_start;
        logic find_step;
        logic close_step;
        logic fill_up;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic shift_done;
        logic full;
        logic cost_done;
        logic find_done;
        logic close_done;
    } status_t;

endpackage

@@ rtl/swm_if.sv @@
// Valid/ready channel interfaces for samples and results.
interface swm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [swm_pkg::SampleWidth-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [swm_pkg::SampleWidth-1:0] median;
    logic        [swm_pkg::CostWidth-1:0]   cost;
    modport source (output valid, output median, output cost, input ready);
    modport sink   (input valid, input median, input cost, output ready);
endinterface

@@ rtl/swm_ctrl.sv @@
// Sequencer for insert, median and cost, and retire phases.
module swm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             flush,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             out_busy,
    input  swm_pkg::status_t status,
    output swm_pkg::cmd_t    cmd
);
    swm_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swm_pkg::ST_IDLE;
        end
        else if (flush)
        begin
            state_reg <= swm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swm_pkg::ST_IDLE:  if (in_valid) state_next = swm_pkg::ST_WRITE;
            swm_pkg::ST_WRITE: state_next = swm_pkg::ST_SCAN;
            swm_pkg::ST_SCAN:  if (status.scan_done) state_next = swm_pkg::ST_SHIFT;
            swm_pkg::ST_SHIFT: if (status.shift_done) state_next = swm_pkg::ST_CHECK;
            swm_pkg::ST_CHECK: state_next = status.full ? swm_pkg::ST_MEDRD
                                                        : swm_pkg::ST_IDLE;
            swm_pkg::ST_MEDRD: state_next = swm_pkg::ST_COST;
            swm_pkg::ST_COST:  if (status.cost_done) state_next = swm_pkg::ST_OUT;
            swm_pkg::ST_OUT:   if (!out_busy) state_next = swm_pkg::ST_FIND;
            swm_pkg::ST_FIND:  if (status.find_done) state_next = swm_pkg::ST_CLOSE;
            swm_pkg::ST_CLOSE: if (status.close_done) state_next = swm_pkg::ST_IDLE;
            default:           state_next = swm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            swm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            swm_pkg::ST_WRITE: begin cmd.write_arrival = 1'b1; cmd.scan_start = 1'b1; end
            swm_pkg::ST_SCAN:  cmd.scan_step = 1'b1;
            swm_pkg::ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                cmd.fill_up = status.shift_done;
            end
            swm_pkg::ST_CHECK: ;
            swm_pkg::ST_MEDRD: begin cmd.med_read = 1'b1; cmd.cost_start = 1'b1; end
            swm_pkg::ST_COST:  cmd.cost_step = 1'b1;
            swm_pkg::ST_OUT:
            begin
                cmd.out_load = !out_busy;
                cmd.find_start = !out_busy;
            end
            swm_pkg::ST_FIND:  cmd.find_step = 1'b1;
            swm_pkg::ST_CLOSE: cmd.close_step = 1'b1;
            default: ;
        endcase
    end
endmodule

@@ rtl/swm_datapath.sv @@
// Arrival ring, sorted store, median read and deviation accumulator.
module swm_datapath #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   flush,
    input  logic [swm_pkg::SizeWidth-1:0]          size_cfg,
    input  logic signed [swm_pkg::SampleWidth-1:0] sample,
    input  swm_pkg::cmd_t                          cmd,
    output swm_pkg::status_t                       status,
    output logic signed [swm_pkg::SampleWidth-1:0] med_out,
    output logic [swm_pkg::CostWidth-1:0]          cost_out
);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int SW = swm_pkg::SampleWidth;

    logic [SW-1:0] arrival_mem [WINDOW_MAX];
    logic [SW-1:0] sorted_mem  [WINDOW_MAX];

    logic [CW-1:0] k_eff;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] oldest_reg;
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] x_reg;
    logic [SW-1:0] rd_reg;
    logic [SW-1:0] med_reg;
    logic [SW-1:0] old_reg;
    logic [swm_pkg::CostWidth-1:0] acc_reg;
    logic          rd_valid_reg;
    logic          phase_reg;
    logic [CW:0]   wsum;
    logic [CW-1:0] wpos;
    logic [CW-1:0] med_idx;

    always_comb
    begin
        if (size_cfg == '0)
        begin
            k_eff = CW'(1);
        end
        else if ({{(CW+1){1'b0}}, size_cfg} > (CW + 1 + swm_pkg::SizeWidth)'(WINDOW_MAX))
        begin
            k_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            k_eff = CW'(size_cfg);
        end
    end

    // ring position: oldest + fill is below 2k, one subtract wraps it
    assign wsum = {1'b0, oldest_reg} + {1'b0, fill_reg};
    assign wpos = (wsum >= {1'b0, k_eff}) ? CW'(wsum - {1'b0, k_eff}) : CW'(wsum);
    assign med_idx = CW'((k_eff - CW'(1)) >> 1);

    logic [SW-1:0] rd_biased, x_biased, med_biased, diff;
    assign rd_biased  = rd_reg ^ {1'b1, {(SW-1){1'b0}}};
    assign x_biased   = x_reg ^ {1'b1, {(SW-1){1'b0}}};
    assign med_biased = med_reg ^ {1'b1, {(SW-1){1'b0}}};
    assign diff = (rd_biased > med_biased) ? rd_biased - med_biased
                                           : med_biased - rd_biased;

    assign status.full       = (fill_reg == k_eff);
    assign status.scan_done  = cmd.scan_step && (phase_reg == 1'b0) && rd_valid_reg &&
                               ((idx_reg == '0) || !(rd_biased > x_biased));
    assign status.shift_done = cmd.shift_step;
    assign status.cost_done  = cmd.cost_step && rd_valid_reg && (idx_reg == k_eff);
    assign status.find_done  = cmd.find_step && rd_valid_reg && (rd_reg == old_reg);
    assign status.close_done = cmd.close_step && rd_valid_reg &&
                               (idx_reg >= CW'(fill_reg - CW'(1)));

    // scan walks down from fill: read slot idx-1, move it up if larger than x
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= sample;
        end
        if (cmd.write_arrival)
        begin
            arrival_mem[AW'(wpos)] <= x_reg;
        end
        rd_valid_reg <= 1'b0;
        if (cmd.scan_start)
        begin
            idx_reg <= fill_reg;
            phase_reg <= 1'b0;
            if (fill_reg != '0)
            begin
                rd_reg <= sorted_mem[AW'(fill_reg - CW'(1))];
                rd_valid_reg <= 1'b1;
            end
            else
            begin
                rd_valid_reg <= 1'b1;
            end
        end
        else if (cmd.scan_step)
        begin
            if (rd_valid_reg && idx_reg != '0 && rd_biased > x_biased)
            begin
                sorted_mem[AW'(idx_reg)] <= rd_reg;
                idx_reg <= idx_reg - CW'(1);
                if (idx_reg > CW'(1))
                begin
                    rd_reg <= sorted_mem[AW'(idx_reg - CW'(2))];
                end
                rd_valid_reg <= 1'b1;
            end
        end
        if (cmd.shift_step)
        begin
            sorted_mem[AW'(idx_reg)] <= x_reg;
        end
        if (cmd.med_read)
        begin
            med_reg <= sorted_mem[AW'(med_idx)];
            old_reg <= arrival_mem[AW'(oldest_reg)];
        end
        if (cmd.cost_start)
        begin
            idx_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.cost_step)
        begin
            if (rd_valid_reg)
            begin
                acc_reg <= acc_reg + swm_pkg::CostWidth'(diff);
            end
            if (idx_reg != k_eff)
            begin
                rd_reg <= sorted_mem[AW'(idx_reg)];
                idx_reg <= idx_reg + CW'(1);
                rd_valid_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            med_out  <= med_reg;
            cost_out <= acc_reg;
        end
        // find: locate first copy of the retired value
        if (cmd.find_start)
        begin
            idx_reg <= '0;
            rd_reg <= sorted_mem[0];
            rd_valid_reg <= 1'b1;
        end
        else if (cmd.find_step && rd_valid_reg && rd_reg != old_reg)
        begin
            rd_reg <= sorted_mem[AW'(idx_reg + CW'(1))];
            idx_reg <= idx_reg + CW'(1);
            rd_valid_reg <= 1'b1;
        end
        else if (cmd.find_step)
        begin
            if (idx_reg + CW'(1) < fill_reg)
            begin
                rd_reg <= sorted_mem[AW'(idx_reg + CW'(1))];
            end
            rd_valid_reg <= 1'b1;
        end
        // close the gap: slot idx takes slot idx+1
        if (cmd.close_step && rd_valid_reg && idx_reg < CW'(fill_reg - CW'(1)))
        begin
            sorted_mem[AW'(idx_reg)] <= rd_reg;
            if (idx_reg + CW'(2) < fill_reg)
            begin
                rd_reg <= sorted_mem[AW'(idx_reg + CW'(2))];
            end
            idx_reg <= idx_reg + CW'(1);
            rd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else if (flush)
        begin
            fill_reg   <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            if (cmd.fill_up)
            begin
                fill_reg <= fill_reg + CW'(1);
            end
            if (status.close_done)
            begin
                fill_reg <= fill_reg - CW'(1);
                oldest_reg <= (oldest_reg + CW'(1) >= k_eff) ? '0 : oldest_reg + CW'(1);
            end
        end
    end
endmodule

@@ rtl/sliding_window_median_cost_top.sv @@
// Top level of the sliding window median and deviation cost block.
// Samples arrive on in_ch and results leave on out_ch, both valid/ready;
// a transfer happens when valid and ready are high at a rising edge.
// window_size is written through cfg_we/cfg_data while the block is idle;
// a write flushes the window so a new one starts filling.
// Each sample is inserted into the sorted store by a downward scan that moves
// one entry a cycle, reading one entry and writing another of that memory in
// each step. Once the window holds K samples, a result follows after a cost
// pass over the K sorted entries and is held in an output register. The
// oldest sample is then removed by a search and a gap close; no new sample
// is taken until that removal has finished.
// When the receiver stalls, the finished result waits in the output
// register and the next result waits until it has been taken.
// Reset empties the window and sets the window size to one; the stores
// need no clearing since only written entries are read.
module sliding_window_median_cost_top #(
    parameter int WINDOW_MAX = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [swm_pkg::SizeWidth-1:0]     cfg_data,
    swm_in_if.sink                            in_ch,
    swm_out_if.source                         out_ch
);
    logic [swm_pkg::SizeWidth-1:0] size_reg;
    logic                          out_valid_reg;
    swm_pkg::cmd_t                 cmd;
    swm_pkg::status_t              status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= swm_pkg::SizeWidth'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid = out_valid_reg;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (cfg_we),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_busy (out_valid_reg && !out_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    swm_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (cfg_we),
        .size_cfg (size_reg),
        .sample   (in_ch.sample),
        .cmd      (cmd),
        .status   (status),
        .med_out  (out_ch.median),
        .cost_out (out_ch.cost)
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.cost))
        else $error("result dropped while stalled");
    a_noload: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ch.ready))
        else $error("result overwritten");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> !in_ch.ready)
        else $error("input accepted during insert");
endmodule

@@ bench/tb_sliding_window_median_cost_top.sv @@
// Testbench for the sliding window median and deviation cost block.
module tb_sliding_window_median_cost_top;

    localparam int WinMax = 1024;
    localparam longint CycleLimit = 3000000;

    typedef struct packed {
        logic signed [swm_pkg::SampleWidth-1:0] median;
        logic        [swm_pkg::CostWidth-1:0]   cost;
    } median_cost_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [swm_pkg::SizeWidth-1:0] cfg_data;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();

    sliding_window_median_cost_top #(.WINDOW_MAX(WinMax)) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source)
    );

    // predictor state: arrival ring and sorted window
    logic signed [swm_pkg::SampleWidth-1:0] ring_q[WinMax];
    logic signed [swm_pkg::SampleWidth-1:0] sorted_q[$];
    int unsigned held;
    int unsigned head;
    int unsigned win_reg;
    median_cost_t expected_q[$];
    int unsigned error_count;
    longint cycle_count;
    bit out_stall_off;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int unsigned window_len();
        if (win_reg == 0) return 1;
        if (win_reg > WinMax) return WinMax;
        return win_reg;
    endfunction

    task automatic report(input string what);
        error_count++;
        $display("error at cycle %0d: %s", cycle_count, what);
    endtask

    // fold one sample into the model window, queue a result once full
    task automatic predict_median(input logic signed [swm_pkg::SampleWidth-1:0] x);
        int unsigned k;
        int unsigned pos;
        median_cost_t r;
        logic signed [swm_pkg::SampleWidth-1:0] old;
        longint dev;
        longint cost_sum;
        k = window_len();
        if (held >= k)
        begin
            held = 0;
            head = 0;
            sorted_q.delete();
        end
        if (head >= k) head = 0;
        ring_q[(head + held) % k] = x;
        pos = 0;
        while (pos < sorted_q.size() && sorted_q[pos] <= x) pos++;
        sorted_q.insert(pos, x);
        held++;
        if (held < k) return;
        r.median = sorted_q[(k - 1) / 2];
        cost_sum = 0;
        foreach (sorted_q[i])
        begin
            dev = longint'(sorted_q[i]) - longint'(r.median);
            cost_sum += (dev < 0) ? -dev : dev;
        end
        r.cost = swm_pkg::CostWidth'(cost_sum);
        expected_q.insert(expected_q.size(), r);
        old = ring_q[head];
        for (int i = 0; i < sorted_q.size(); i++)
        begin
            if (sorted_q[i] == old)
            begin
                sorted_q.delete(i);
                break;
            end
        end
        held--;
        head = (head + 1) % k;
    endtask

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(input logic signed [swm_pkg::SampleWidth-1:0] x);
        int unsigned gap;
        gap = gap_len();
        // wait a random gap, never none, between dropping and raising valid
        repeat (gap + 1) @(posedge clk);
        in_ch.valid  <= 1'b1;
        in_ch.sample <= x;
        do @(posedge clk); while (!in_ch.ready);
        predict_median(x);
        in_ch.valid <= 1'b0;
    endtask

    // idle until every result is back, then let the block finish a removal
    task automatic drain();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (3 * WinMax + 50) @(posedge clk);
    endtask

    task automatic write_window(input int unsigned size);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= size[swm_pkg::SizeWidth-1:0];
        @(posedge clk);
        cfg_we  <= 1'b0;
        win_reg = size & 11'h7ff;
        held = 0;
        head = 0;
        sorted_q.delete();
    endtask

    function automatic logic signed [swm_pkg::SampleWidth-1:0] rand_sample();
        int unsigned p;
        p = $urandom_range(0, 9);
        if (p < 2) return $signed($urandom_range(0, 6)) - 3;
        if (p == 2) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        return $signed($urandom);
    endfunction

    always @(posedge clk)
    begin
        median_cost_t r;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    r = expected_q.pop_front();
                    if (out_ch.median !== r.median)
                        report($sformatf("median %0d, expected %0d", out_ch.median, r.median));
                    if (out_ch.cost !== r.cost)
                        report($sformatf("cost %0d, expected %0d", out_ch.cost, r.cost));
                end
            end
            out_ch.ready <= out_stall_off ? 1'b1 : ($urandom_range(0, 9) < 7);
        end
    end

    always
    begin
        #1000 out_stall_off = $urandom_range(0, 3) == 0;
    end

    task automatic test_reset_size();
        // window of one: median is the sample itself, cost zero
        send_sample(32'sh7fffffff);
        send_sample(32'sh80000000);
        send_sample(0);
        send_sample(-1);
    endtask

    task automatic test_extremes();
        write_window(3);
        send_sample(32'sh80000000);
        send_sample(32'sh7fffffff);
        send_sample(32'sh7fffffff);
        send_sample(32'sh80000000);
        send_sample(5);
        write_window(4);
        repeat (4) send_sample(7);
        send_sample(-7);
        send_sample(7);
    endtask

    task automatic test_size_zero();
        write_window(0);
        send_sample(11);
        send_sample(-11);
    endtask

    task automatic test_size_max();
        // oversized window saturates; no result may show while it fills
        write_window(2047);
        repeat (200) send_sample(rand_sample());
        write_window(WinMax);
        repeat (20) send_sample(rand_sample());
    endtask

    task automatic test_random();
        int unsigned sizes[6] = '{1, 2, 5, 8, 17, 64};
        repeat (6)
        begin
            write_window(sizes[$urandom_range(0, 5)]);
            repeat (100) send_sample(rand_sample());
        end
        // partial fill, then reconfigure before the window completes
        write_window(9);
        repeat (5) send_sample(rand_sample());
        write_window(2);
        repeat (10) send_sample(rand_sample());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        out_stall_off = 1'b0;
        cycle_count = 0;
        error_count = 0;
        win_reg = 1;
        held = 0;
        head = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_size();
        test_extremes();
        test_size_zero();
        test_random();
        test_size_max();
        drain();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
